// ===== rtl/core/sbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

    // Storage depth and register defaults
    localparam int DEPTH_DEFAULT = 16;
    localparam int SYM_W         = 8;
    localparam int IDX_W         = 4;
    localparam int CNT_W         = 5;
    localparam int STAT_W        = 3;
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ_OK  = 3'd3,
        ST_READ_OOR = 3'd4
    } t_status;

    // Control handed to each cell of the row
    typedef struct packed {
        logic                    shift_en;
        logic signed [SYM_W-1:0] symbol;
        logic                    occupied;
        logic                    rd_hit;
    } t_cell_ctl;

    // Compare flags returned by each cell
    typedef struct packed {
        logic ge;
        logic eq;
    } t_cell_flags;

endpackage

`default_nettype wire

// ===== rtl/core/sbs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbs_cell (
    input  wire logic                            i_clk,
    input  wire sbs_pkg::t_cell_ctl              i_ctl,
    input  wire logic signed [sbs_pkg::SYM_W-1:0] i_left_entry,
    input  wire logic                            i_left_ge,
    output logic signed [sbs_pkg::SYM_W-1:0]     o_entry,
    output sbs_pkg::t_cell_flags                 o_flags,
    output logic signed [sbs_pkg::SYM_W-1:0]     o_rd_data
);
    import sbs_pkg::*;

    logic signed [SYM_W-1:0] r_entry;
    logic signed [SYM_W-1:0] n_entry;

    // Compare the held entry against the broadcast symbol
    always_comb begin
        o_flags.ge = !i_ctl.occupied || (r_entry >= i_ctl.symbol);
        o_flags.eq = i_ctl.occupied && (r_entry == i_ctl.symbol);
    end

    // Take the left neighbor past the insert point, the symbol at it, else hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_en) begin
            if (i_left_ge) begin
                n_entry = i_left_entry;
            end else if (o_flags.ge) begin
                n_entry = i_ctl.symbol;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry   = r_entry;
    assign o_rd_data = i_ctl.rd_hit ? r_entry : '0;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_byte_set_insert.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted set of signed 8-bit symbols held in a row of compare-and-shift cells.
// Each beat either inserts a symbol (refused with status full when the count
// has reached the smaller of the capacity register and DEPTH, reported as
// present when already held, otherwise placed in ascending order) or reads the
// entry at an index. Every input beat yields one result beat in the cycle after
// acceptance, and a new beat is taken every cycle unless input stalls: all cells
// compare against the symbol and shift in the same clock, so the row keeps pace.
// The result sits in an output register; input stalls only while that
// register holds a beat the consumer is stalling. Write capacity only while idle.
module sorted_byte_set_insert #(
    parameter int DEPTH = sbs_pkg::DEPTH_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sbs_pkg::CNT_W-1:0]        i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_opcode,
    input  wire logic signed [sbs_pkg::SYM_W-1:0] i_symbol,
    input  wire logic [sbs_pkg::IDX_W-1:0]        i_index,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [sbs_pkg::STAT_W-1:0]            o_status,
    output logic [sbs_pkg::IDX_W-1:0]             o_position,
    output logic [sbs_pkg::CNT_W-1:0]             o_count,
    output logic signed [sbs_pkg::SYM_W-1:0]      o_read_value
);
    import sbs_pkg::*;

    localparam int HW = $clog2(DEPTH + 1);
    localparam int CW = (HW > CNT_W) ? HW : CNT_W;
    localparam int IW = (HW > IDX_W) ? HW : IDX_W;
    localparam logic [HW-1:0] DEPTH_H = HW'(DEPTH);

    logic [HW-1:0]           r_held;
    logic [HW-1:0]           n_held;
    logic [CNT_W-1:0]        r_capacity;
    logic                    r_out_valid;
    t_status                 r_status;
    t_status                 n_status;
    logic [IDX_W-1:0]        r_position;
    logic [IDX_W-1:0]        n_position;
    logic [CNT_W-1:0]        r_count;
    logic signed [SYM_W-1:0] r_read_value;
    logic signed [SYM_W-1:0] n_read_value;

    logic                    in_acc;
    logic                    is_full;
    logic                    found;
    logic                    rd_in_range;
    logic                    shift_en;
    logic [IDX_W-1:0]        ins_pos;
    logic signed [SYM_W-1:0] rd_value;
    logic [CW-1:0]           count_x;

    t_cell_ctl               cell_ctl  [DEPTH];
    t_cell_flags             cell_flg  [DEPTH];
    logic signed [SYM_W-1:0] cell_ent  [DEPTH];
    logic signed [SYM_W-1:0] cell_rd   [DEPTH];
    logic [DEPTH-1:0]        eq_vec;
    logic [DEPTH-1:0]        first_vec;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Limit is the smaller of capacity and DEPTH
    assign is_full = (CW'(r_held) >= CW'(r_capacity)) || (r_held == DEPTH_H);
    assign found   = |eq_vec;
    assign rd_in_range = IW'(i_index) < IW'(r_held);
    assign shift_en = in_acc && (t_opcode'(i_opcode) == OP_INSERT) && !is_full && !found;

    // Row of cells, each handing its entry and compare flag to the right
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [HW-1:0] IDX_H = HW'(g);
        localparam logic [IW-1:0] IDX_I = IW'(g);
        logic signed [SYM_W-1:0] left_entry;
        logic                    left_ge;

        always_comb begin
            cell_ctl[g].shift_en = shift_en;
            cell_ctl[g].symbol   = i_symbol;
            cell_ctl[g].occupied = IDX_H < r_held;
            cell_ctl[g].rd_hit   = (IW'(i_index) == IDX_I) && (IDX_H < r_held);
        end

        if (g == 0) begin : g_head
            assign left_entry = '0;
            assign left_ge    = 1'b0;
        end else begin : g_body
            assign left_entry = cell_ent[g-1];
            assign left_ge    = cell_flg[g-1].ge;
        end

        sbs_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[g]),
            .i_left_entry (left_entry),
            .i_left_ge    (left_ge),
            .o_entry      (cell_ent[g]),
            .o_flags      (cell_flg[g]),
            .o_rd_data    (cell_rd[g])
        );

        assign eq_vec[g]    = cell_flg[g].eq;
        assign first_vec[g] = (g == 0) ? cell_flg[g].ge
                                       : (cell_flg[g].ge && !left_ge);
    end

    // Encode the insert point and gather the read data
    always_comb begin
        ins_pos  = '0;
        rd_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            ins_pos  = ins_pos | (first_vec[i] ? IDX_W'(i) : '0);
            rd_value = rd_value | cell_rd[i];
        end
    end

    // Result of the accepted beat
    always_comb begin
        n_held       = r_held;
        n_status     = ST_FULL;
        n_position   = '0;
        n_read_value = '0;
        if (t_opcode'(i_opcode) == OP_READ) begin
            n_position = i_index;
            if (rd_in_range) begin
                n_status     = ST_READ_OK;
                n_read_value = rd_value;
            end else begin
                n_status = ST_READ_OOR;
            end
        end else if (is_full) begin
            n_status = ST_FULL;
        end else if (found) begin
            n_status   = ST_PRESENT;
            n_position = ins_pos;
        end else begin
            n_status   = ST_INSERTED;
            n_position = ins_pos;
            n_held     = r_held + HW'(1);
        end
    end

    assign count_x = CW'(n_held);

    // Control state: count, capacity, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (in_acc) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status     <= n_status;
            r_position   <= n_position;
            r_count      <= count_x[CNT_W-1:0];
            r_read_value <= n_read_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_position   = r_position;
    assign o_count      = r_count;
    assign o_read_value = r_read_value;

    // Count never exceeds the storage depth
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= DEPTH_H)
        else $error("held count beyond depth");

    // A successful insert grows the set by exactly one
    a_held_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_status == ST_INSERTED) |=> (r_held == $past(r_held) + HW'(1)))
        else $error("insert did not advance count");

    // Sorted row: compare flags switch on at one place at most
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first_vec))
        else $error("cell row out of order");

    // No duplicate symbols held
    a_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(eq_vec))
        else $error("duplicate symbol in set");

    // Count holds when no beat is accepted
    a_held_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_held))
        else $error("count changed without a beat");

endmodule

`default_nettype wire
